@@ sv/lkv_pkg.sv @@
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int AGE_W       = $clog2(MAX_ENTRIES);
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CMP_W       = (CAP_W > OCC_W) ? CAP_W : OCC_W;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } rsp_t;

endpackage

@@ sv/lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// A get beat is held in the request register, then in the result register
// once it frees. Throughput: one beat per cycle unless a get waits on a
//   stalled result; 16-way key compare and age update are combinational.
// Reset: rst_n is synchronous, active low; it empties the cache, clears
//   the ages and occupancy and sets the capacity register to 16.

module lru_key_value_cache (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,    // capacity
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // key [31:0], value [63:32]
  input  logic [0:0]  in_tuser,     // opcode: 0 get, 1 put
  // result channel, one beat per get
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // read_value
  output logic [0:0]  out_tuser     // hit
);

  lkv_pkg::req_t req;
  lkv_pkg::rsp_t rsp;
  logic          req_valid;
  logic          out_free;
  logic          advance;
  logic          load;

  // A put never needs the result register, so it retires even while a
  // get result is stalled. A get waits until the result register frees.
  assign advance = req_valid && ((req.op == lkv_pkg::OP_PUT) || out_free);
  assign load    = advance && (req.op == lkv_pkg::OP_GET);

  lkv_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  // Entry array: keys, values, valid bits, ages and occupancy. State
  // updates at the edge where the request retires, so the next request
  // sees it in the following cycle without any forwarding.
  lkv_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .req_go    (advance),
    .rsp       (rsp)
  );

  lkv_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .rsp        (rsp),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ sv/lkv_in_stage.sv @@
`timescale 1ns / 1ps

module lkv_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // key, value
  input  logic [0:0]            in_tuser,   // opcode
  input  logic                  advance,
  output logic                  req_valid,
  output lkv_pkg::req_t         req
);

  logic          valid_r, valid_nxt;
  lkv_pkg::req_t req_r;

  assign in_tready = !valid_r || advance;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture a beat whenever the stage is free or drains this cycle.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.op    <= lkv_pkg::op_t'(in_tuser[0]);
      req_r.key   <= in_tdata[lkv_pkg::KEY_W-1:0];
      req_r.value <= in_tdata[lkv_pkg::KEY_W +: lkv_pkg::VAL_W];
    end
  end

endmodule

@@ sv/lkv_store.sv @@
`timescale 1ns / 1ps

module lkv_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
  input  lkv_pkg::req_t             req,
  input  logic                      req_go,
  output lkv_pkg::rsp_t             rsp
);

  localparam int N = lkv_pkg::MAX_ENTRIES;

  logic [lkv_pkg::KEY_W-1:0] key_r   [N];
  logic [lkv_pkg::VAL_W-1:0] value_r [N];
  logic [N-1:0]              valid_r, valid_nxt;
  logic [lkv_pkg::AGE_W-1:0] age_r   [N];
  logic [lkv_pkg::AGE_W-1:0] age_nxt [N];
  logic [lkv_pkg::OCC_W-1:0] occ_r, occ_nxt;
  logic [lkv_pkg::CAP_W-1:0] cap_r;

  logic [N-1:0]              match, free_oh, victim, target;
  logic                      hit, is_put, do_fill, update;
  logic [lkv_pkg::AGE_W-1:0] hit_age, ref_age, oldest_age;
  logic [lkv_pkg::VAL_W-1:0] hit_value;
  logic [lkv_pkg::CMP_W-1:0] cap_ext, eff_cap, occ_ext;

  always_comb begin
    is_put = (req.op == lkv_pkg::OP_PUT);

    // Effective capacity: zero reads as one, saturate at the array depth.
    cap_ext = lkv_pkg::CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = lkv_pkg::CMP_W'(1);
    end else if (cap_ext > lkv_pkg::CMP_W'(N)) begin
      eff_cap = lkv_pkg::CMP_W'(N);
    end else begin
      eff_cap = cap_ext;
    end
    occ_ext = lkv_pkg::CMP_W'(occ_r);

    // Valid ages are distinct 0..occ-1, so the least recent holds occ-1.
    oldest_age = lkv_pkg::AGE_W'(occ_r - lkv_pkg::OCC_W'(1));

    hit_age   = '0;
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == req.key);
      victim[i] = valid_r[i] && (age_r[i] == oldest_age);
      hit_age   = hit_age | (age_r[i] & {lkv_pkg::AGE_W{match[i]}});
      hit_value = hit_value | (value_r[i] & {lkv_pkg::VAL_W{match[i]}});
    end
    hit = |match;

    // Lowest clear valid bit.
    free_oh = ~valid_r & (valid_r + N'(1));

    do_fill = is_put && !hit && (occ_ext < eff_cap);
    if (hit) begin
      target = match;
    end else if (do_fill) begin
      target = free_oh;
    end else begin
      target = victim;
    end
    ref_age = hit ? hit_age : oldest_age;
    update  = req_go && (hit || is_put);

    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < N; i++) begin
      age_nxt[i] = age_r[i];
      if (update) begin
        if (target[i]) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && (do_fill || (age_r[i] < ref_age))) begin
          age_nxt[i] = age_r[i] + lkv_pkg::AGE_W'(1);
        end
      end
    end
    if (update && do_fill) begin
      valid_nxt = valid_r | free_oh;
      occ_nxt   = occ_r + lkv_pkg::OCC_W'(1);
    end

    rsp.hit   = hit;
    rsp.value = hit ? hit_value : lkv_pkg::MISS_VALUE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= lkv_pkg::CAP_RESET;
      for (int i = 0; i < N; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < N; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (update && is_put && target[i]) begin
        value_r[i] <= req.value;
        if (!hit) begin
          key_r[i] <= req.key;
        end
      end
    end
  end

endmodule

@@ sv/lkv_out_stage.sv @@
`timescale 1ns / 1ps

module lkv_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  lkv_pkg::rsp_t             rsp,
  output logic                      free,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [lkv_pkg::VAL_W-1:0] out_tdata,   // read_value
  output logic [0:0]                out_tuser    // hit
);

  logic          valid_r, valid_nxt;
  lkv_pkg::rsp_t rsp_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = rsp_r.value;
  assign out_tuser  = rsp_r.hit;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp;
    end
  end

endmodule

@@ sv/lkv_checker.sv @@
`timescale 1ns / 1ps

module lkv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // A miss always reports all ones.
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'hFFFF_FFFF)
    else $error("miss without all-ones value");

  // A fresh result must trace back to an accepted get, through the request and result registers.
  a_get_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && !in_tuser[0], 2))
    else $error("result without a matching get");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
